[hdl/bpwm_pkg.sv]
// shared types, constants and digit helpers for the breathing pwm led block
`default_nettype none
package bpwm_pkg;

	localparam int unsigned DIGIT_COUNT_DEF = 8;
	localparam int unsigned SCAN_W = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [7:0] PWM_PERIOD_RST = 8'd100;
	localparam logic [6:0] DUTY_LIMIT_RST = 7'd100;
	localparam logic [9:0] RAMP_PERIOD_RST = 10'd100;
	localparam logic [7:0] BUZZER_DIV_RST = 8'd2;
	localparam logic [6:0] DUTY_RST = 7'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PWM_PERIOD  = 2'd0,
		REG_DUTY_LIMIT  = 2'd1,
		REG_RAMP_PERIOD = 2'd2,
		REG_BUZZER_DIV  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] pwm_period;
		logic [6:0] duty_limit;
		logic [9:0] ramp_period_ms;
		logic [7:0] buzzer_divider;
	} cfg_t;

	typedef struct packed {
		logic             led_level;
		logic             buzzer_level;
		logic [SCAN_W-1:0] digit_select;
		logic [7:0]       segments;
	} result_t;

	// seven-segment font, blank for codes of ten and above
	function automatic logic [7:0] digit_pattern(input logic [3:0] v);
		logic [7:0] p;
		case (v)
			4'd0: p = 8'h3F;
			4'd1: p = 8'h06;
			4'd2: p = 8'h5B;
			4'd3: p = 8'h4F;
			4'd4: p = 8'h66;
			4'd5: p = 8'h6D;
			4'd6: p = 8'h7D;
			4'd7: p = 8'h07;
			4'd8: p = 8'h7F;
			4'd9: p = 8'h6F;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

	// tens digit by reciprocal multiply, exact for 7-bit values
	function automatic logic [3:0] tens_of(input logic [6:0] d);
		logic [14:0] prod;
		prod = 15'(d) * 15'd205;
		return prod[14:11];
	endfunction

	function automatic logic [3:0] units_of(input logic [6:0] d);
		logic [3:0] t;
		logic [6:0] r;
		t = tens_of(d);
		r = d - 7'(t) * 7'd10;
		return r[3:0];
	endfunction

endpackage
`default_nettype wire

[hdl/bpwm_cfg.sv]
// configuration register file
`default_nettype none
module bpwm_cfg
	import bpwm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_period     <= PWM_PERIOD_RST;
			cfg_q.duty_limit     <= DUTY_LIMIT_RST;
			cfg_q.ramp_period_ms <= RAMP_PERIOD_RST;
			cfg_q.buzzer_divider <= BUZZER_DIV_RST;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_PWM_PERIOD:  cfg_q.pwm_period     <= wr_data[7:0];
				REG_DUTY_LIMIT:  cfg_q.duty_limit     <= wr_data[6:0];
				REG_RAMP_PERIOD: cfg_q.ramp_period_ms <= wr_data[9:0];
				REG_BUZZER_DIV:  cfg_q.buzzer_divider <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[hdl/bpwm_tick.sv]
// per-tick state update: ramp, key, buzzer, pwm and digit scan
`default_nettype none
module bpwm_tick
	import bpwm_pkg::*;
#(
	parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic step,
	input  wire logic key,
	output result_t   res
);

	localparam logic [SCAN_W:0] LAST_POS = (SCAN_W+1)'(DIGIT_COUNT);

	logic [6:0]        duty_q, duty_n;
	logic              up_q, up_n;
	logic              em_q, em_n;
	logic              last_key_q, last_key_n;
	logic [7:0]        pwm_q, pwm_n;
	logic [7:0]        bz_cnt_q, bz_cnt_n;
	logic              bz_q, bz_n;
	logic [SCAN_W-1:0] scan_q, scan_n;
	logic [9:0]        ramp_q, ramp_n;

	logic [10:0]       ramp_inc;
	logic              ramp_tick;
	logic [8:0]        bz_inc;
	logic [8:0]        pwm_inc;
	logic [SCAN_W:0]   pos;
	logic [7:0]        seg;

	always_comb begin
		ramp_inc   = {1'b0, ramp_q} + 11'd1;
		ramp_tick  = ramp_inc >= {1'b0, cfg.ramp_period_ms};
		ramp_n     = ramp_tick ? 10'd0 : ramp_inc[9:0];
		duty_n     = duty_q;
		up_n       = up_q;
		em_n       = em_q;
		last_key_n = last_key_q;
		if (ramp_tick) begin
			if (!em_q) begin
				if (up_q) begin
					if (duty_q < cfg.duty_limit)
						duty_n = duty_q + 7'd1;
					if (duty_n >= cfg.duty_limit)
						up_n = 1'b0;
				end else begin
					if (duty_q != 7'd0)
						duty_n = duty_q - 7'd1;
					if (duty_n == 7'd0)
						up_n = 1'b1;
				end
			end
			if (!key && last_key_q)
				em_n = !em_q;
			last_key_n = key;
		end

		// buzzer count holds while in emergency mode
		bz_inc   = {1'b0, bz_cnt_q} + 9'd1;
		bz_cnt_n = bz_cnt_q;
		bz_n     = bz_q;
		if (!em_n) begin
			if (bz_inc >= {1'b0, cfg.buzzer_divider}) begin
				bz_n     = !bz_q;
				bz_cnt_n = 8'd0;
			end else begin
				bz_cnt_n = bz_inc[7:0];
			end
		end else begin
			bz_n = 1'b0;
		end

		pwm_inc = {1'b0, pwm_q} + 9'd1;
		pwm_n   = (pwm_inc >= {1'b0, cfg.pwm_period}) ? 8'd0 : pwm_inc[7:0];

		pos = {1'b0, scan_q} + (SCAN_W+1)'(1);
		if (pos == (SCAN_W+1)'(1))
			seg = digit_pattern(tens_of(duty_n));
		else if (pos == (SCAN_W+1)'(2))
			seg = digit_pattern(units_of(duty_n));
		else if (pos == LAST_POS)
			seg = digit_pattern({3'd0, em_n});
		else
			seg = 8'h00;
		scan_n = (pos >= LAST_POS) ? '0 : pos[SCAN_W-1:0];

		res.led_level    = em_n ? 1'b0 : ((pwm_n < {1'b0, duty_n}) ? 1'b0 : 1'b1);
		res.buzzer_level = bz_n;
		res.digit_select = scan_q;
		res.segments     = seg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q     <= DUTY_RST;
			up_q       <= 1'b1;
			em_q       <= 1'b0;
			last_key_q <= 1'b1;
			pwm_q      <= 8'd0;
			bz_cnt_q   <= 8'd0;
			bz_q       <= 1'b1;
			scan_q     <= '0;
			ramp_q     <= 10'd0;
		end else if (step) begin
			duty_q     <= duty_n;
			up_q       <= up_n;
			em_q       <= em_n;
			last_key_q <= last_key_n;
			pwm_q      <= pwm_n;
			bz_cnt_q   <= bz_cnt_n;
			bz_q       <= bz_n;
			scan_q     <= scan_n;
			ramp_q     <= ramp_n;
		end
	end

endmodule
`default_nettype wire

[hdl/breathing_pwm_led_with_digit_scan_core.sv]
// top level of the breathing pwm led with buzzer and digit scan
// a word accepted into the input register is presented once it moves into the output register
// throughput: one word per cycle while the output is not stalled
// the input register lets a new word in while a finished word waits on the output
// reset (arst_n low, asynchronous): registers to defaults, duty 5, ramping up, normal mode
`default_nettype none
module breathing_pwm_led_with_digit_scan_core
	import bpwm_pkg::*;
#(
	parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// tick input channel
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  key_level,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       led_level,
	output logic                       buzzer_level,
	output logic [SCAN_W-1:0]          digit_select,
	output logic [7:0]                 segments,
	// configuration write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	result_t res;
	result_t res_q;

	logic    valid_s1;
	logic    key_s1;
	logic    out_valid_q;
	logic    advance;

	// registers are always writable
	assign cfg_ready = 1'b1;

	bpwm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// a held word moves into the output register when that register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			key_s1 <= key_level;
	end

	// state is committed in the same cycle the word lands in the output register
	bpwm_tick #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_tick (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.key    (key_s1),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign led_level    = res_q.led_level;
	assign buzzer_level = res_q.buzzer_level;
	assign digit_select = res_q.digit_select;
	assign segments     = res_q.segments;

endmodule
`default_nettype wire

[tb/breathing_pwm_led_with_digit_scan_core_tb.sv]
// self-checking testbench for the breathing pwm led, buzzer and digit scan core
`timescale 1ns / 100ps
module breathing_pwm_led_with_digit_scan_core_tb;
	import bpwm_pkg::*;

	localparam int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF;
	localparam int unsigned CYCLE_LIMIT = 200_000;
	// directed ticks plus the random ones
	localparam int unsigned TICK_TARGET = 420;
	// room kept below the tick target before a full-duty climb is started
	localparam int unsigned CLIMB_MAX = 240;
	// digit code that shows nothing
	localparam int unsigned BLANK_CODE = 10;
	// seven-segment glyphs, element 0 is the digit zero
	localparam logic [9:0][7:0] SEG_FONT = {
		8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// tick channel
	logic in_valid = 1'b0;
	logic in_ready;
	logic key_level = 1'b1;

	// result channel
	logic out_valid;
	logic out_ready = 1'b0;
	logic led_level;
	logic buzzer_level;
	logic [SCAN_W-1:0] digit_select;
	logic [7:0] segments;

	// register write channel
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = REG_PWM_PERIOD;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	breathing_pwm_led_with_digit_scan_core #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.key_level(key_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.led_level(led_level),
		.buzzer_level(buzzer_level),
		.digit_select(digit_select),
		.segments(segments),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// mirror of the block's registers and state, reset values
	cfg_t regs = '{
		pwm_period: PWM_PERIOD_RST,
		duty_limit: DUTY_LIMIT_RST,
		ramp_period_ms: RAMP_PERIOD_RST,
		buzzer_divider: BUZZER_DIV_RST
	};
	logic [6:0] duty_now = DUTY_RST;
	logic rising = 1'b1;
	logic emergency = 1'b0;
	logic key_prev = 1'b1;
	logic [7:0] pwm_cnt = '0;
	logic [7:0] buzz_cnt = '0;
	logic buzz_pin = 1'b1;
	logic [SCAN_W-1:0] digit_slot = '0;
	logic [9:0] ramp_cnt = '0;

	// key levels waiting to go out, and pin levels still owed by the block
	bit keys_to_send[$];
	result_t pin_levels_due[$];

	int unsigned keys_queued = 0;
	int unsigned tick_gap = 0;
	int unsigned hold_left = 0;
	int unsigned pause = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	bit mismatch_seen = 1'b0;
	result_t seen_word;
	result_t due_word;

	// one millisecond tick: ramp work first, then buzzer, pwm and the scanned digit
	function automatic result_t advance_tick(input logic key);
		result_t word;
		int unsigned next_cnt;
		int unsigned pos;
		int unsigned shown;
		word = '0;
		next_cnt = ramp_cnt + 1;
		if (next_cnt >= regs.ramp_period_ms) begin
			ramp_cnt = '0;
			// duty frozen while in emergency mode
			if (!emergency) begin
				if (rising) begin
					if (duty_now < regs.duty_limit)
						duty_now = duty_now + 7'd1;
					if (duty_now >= regs.duty_limit)
						rising = 1'b0;
				end else begin
					if (duty_now != 7'd0)
						duty_now = duty_now - 7'd1;
					if (duty_now == 7'd0)
						rising = 1'b1;
				end
			end
			// key is only looked at on ramp ticks, a press toggles the mode
			if (!key && key_prev)
				emergency = ~emergency;
			key_prev = key;
		end else begin
			ramp_cnt = 10'(next_cnt);
		end

		// buzzer count holds its value in emergency mode
		if (!emergency) begin
			next_cnt = buzz_cnt + 1;
			if (next_cnt >= regs.buzzer_divider) begin
				buzz_pin = ~buzz_pin;
				buzz_cnt = '0;
			end else begin
				buzz_cnt = 8'(next_cnt);
			end
		end else begin
			buzz_pin = 1'b0;
		end

		next_cnt = pwm_cnt + 1;
		pwm_cnt = (next_cnt >= regs.pwm_period) ? 8'd0 : 8'(next_cnt);
		word.led_level = emergency ? 1'b0 : ~(pwm_cnt < {1'b0, duty_now});
		word.buzzer_level = buzz_pin;

		// tens on the first position, units on the second, mode bit on the last
		pos = digit_slot + 1;
		shown = BLANK_CODE;
		if (pos == 1)
			shown = duty_now / 7'd10;
		else if (pos == 2)
			shown = duty_now % 7'd10;
		else if (pos == DIGIT_COUNT)
			shown = emergency;
		word.segments = (shown < BLANK_CODE) ? SEG_FONT[shown] : 8'h00;
		word.digit_select = digit_slot;
		digit_slot = (pos >= DIGIT_COUNT) ? '0 : SCAN_W'(pos);
		return word;
	endfunction

	task automatic compare_field(input string what, input int unsigned want,
			input int unsigned seen);
		if (want != seen) begin
			mismatch_seen = 1'b1;
			mismatches++;
			// keep the log short when the block is badly off
			if (mismatches <= 100)
				$display("%0t: %s expected %0d actual %0d", $time, what, want, seen);
		end
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	// free-running guard against a hung handshake
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("breathing_pwm_led_with_digit_scan_core_tb NOT OK");
		$finish;
	end

	// tick driver: predicts on each accepted word, then offers the next key level
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tick_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				pin_levels_due.push_back(advance_tick(key_level));
			if (!in_valid || in_ready) begin
				if (tick_gap != 0) begin
					tick_gap <= tick_gap - 1;
					in_valid <= 1'b0;
				end else if (keys_to_send.size() != 0) begin
					in_valid <= 1'b1;
					key_level <= keys_to_send.pop_front();
					tick_gap <= gaps_on ? $urandom_range(0, 3) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure after each word while stalls are on
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen_word.led_level = led_level;
				seen_word.buzzer_level = buzzer_level;
				seen_word.digit_select = digit_select;
				seen_word.segments = segments;
				if (pin_levels_due.size() == 0) begin
					mismatch_seen = 1'b1;
					$display("%0t: word with nothing pending, expected none actual %0h",
						$time, seen_word);
				end else begin
					due_word = pin_levels_due.pop_front();
					compare_field("led_level", due_word.led_level, seen_word.led_level);
					compare_field("buzzer_level", due_word.buzzer_level,
						seen_word.buzzer_level);
					compare_field("digit_select", due_word.digit_select,
						seen_word.digit_select);
					compare_field("segments", due_word.segments, seen_word.segments);
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready && stalls_on) begin
				pause = $urandom_range(0, 3);
				hold_left <= (pause == 0) ? 0 : pause - 1;
				out_ready <= (pause == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_key(input bit lvl);
		keys_to_send.push_back(lvl);
		keys_queued++;
	endtask

	// hold the sender until every owed word is back and the core has settled
	task automatic wait_quiet();
		do @(negedge clk);
		while (keys_to_send.size() != 0 || in_valid || pin_levels_due.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PWM_PERIOD: regs.pwm_period = val[7:0];
			REG_DUTY_LIMIT: regs.duty_limit = val[6:0];
			REG_RAMP_PERIOD: regs.ramp_period_ms = val[9:0];
			REG_BUZZER_DIV: regs.buzzer_divider = val[7:0];
			default: ;
		endcase
	endtask

	// rewrite all four registers, then step off the clock edge before queuing ticks
	task automatic set_regs(input logic [7:0] pwm, input logic [6:0] lim,
			input logic [9:0] ramp, input logic [7:0] buzz);
		write_reg(REG_PWM_PERIOD, CFG_DATA_W'(pwm));
		write_reg(REG_DUTY_LIMIT, CFG_DATA_W'(lim));
		write_reg(REG_RAMP_PERIOD, ramp);
		write_reg(REG_BUZZER_DIV, CFG_DATA_W'(buzz));
		@(negedge clk);
	endtask

	task automatic send_keys(input int unsigned count, input bit noisy);
		int unsigned run;
		bit lvl;
		run = 0;
		lvl = 1'b0;
		repeat (count) begin
			if (noisy) begin
				send_key(1'($urandom_range(0, 1)));
			end else begin
				// long released stretches broken by short presses
				if (run == 0) begin
					lvl = ~lvl;
					run = lvl ? $urandom_range(1, 20) : $urandom_range(1, 4);
				end
				send_key(lvl);
				run--;
			end
		end
	endtask

	// ramp the duty all the way to 100 and freeze it there with a press,
	// so the blank tens digit and the mode digit are both scanned
	task automatic climb_to_full_duty();
		int unsigned n;
		set_regs(8'd100, 7'd100, 10'd1, 8'($urandom_range(1, 255)));
		if (emergency) begin
			send_key(1'b1);
			send_key(1'b0);
		end
		send_key(1'b1);
		wait_quiet();
		// walk down to zero first if the ramp is not on its way up below 100
		if (!rising || duty_now >= 7'd100) begin
			n = rising + duty_now;
			if (n == 0)
				n = 1;
			repeat (n) send_key(1'b1);
			wait_quiet();
		end
		n = 99 - int'(duty_now);
		repeat (n) send_key(1'b1);
		send_key(1'b0);
		repeat (12) send_key(1'b1);
		send_key(1'b0);
		repeat (4) send_key(1'b1);
		wait_quiet();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: no ramp tick comes this early, a press goes unseen
		send_key(1'b1);
		send_key(1'b0);
		send_key(1'b1);
		send_key(1'b1);
		wait_quiet();

		// zero everywhere: every tick ramps, pwm stuck at 0, buzzer toggles each tick outside emergency mode
		set_regs(8'd0, 7'd0, 10'd0, 8'd0);
		send_key(1'b0);
		send_key(1'b1);
		send_key(1'b0);
		send_key(1'b0);
		send_key(1'b1);
		wait_quiet();

		// ones everywhere: limit of one, pwm counter still held at 0
		set_regs(8'd1, 7'd1, 10'd1, 8'd1);
		send_key(1'b1);
		send_key(1'b1);
		send_key(1'b1);
		send_key(1'b0);
		send_key(1'b1);
		wait_quiet();

		// widest values of every register
		set_regs(8'd255, 7'd127, 10'd1023, 8'd255);
		send_key(1'b1);
		send_key(1'b0);
		send_key(1'b1);
		wait_quiet();

		// short pwm, ramp every other tick, key edges landing on both phases
		set_regs(8'd2, 7'd100, 10'd2, 8'd1);
		send_key(1'b1);
		send_key(1'b0);
		send_key(1'b1);
		send_key(1'b1);
		send_key(1'b0);
		send_key(1'b1);
		send_key(1'b1);
		send_key(1'b1);
		wait_quiet();

		climb_to_full_duty();

		// random phases, each with its own settings and idling pattern
		while (keys_queued < TICK_TARGET) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 7) == 0 && keys_queued + CLIMB_MAX < TICK_TARGET) begin
				climb_to_full_duty();
			end else begin
				set_regs(
					($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(2, 24)),
					($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
						: 7'($urandom_range(1, 100)),
					($urandom_range(0, 5) == 0) ? 10'($urandom_range(0, 1023))
						: 10'($urandom_range(1, 5)),
					($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(1, 6)));
				send_keys($urandom_range(30, 80), $urandom_range(0, 4) == 0);
				wait_quiet();
			end
		end

		wait_quiet();
		repeat (10) @(negedge clk);
		if (!mismatch_seen && pin_levels_due.size() == 0)
			$display("breathing_pwm_led_with_digit_scan_core_tb OK");
		else
			$display("breathing_pwm_led_with_digit_scan_core_tb NOT OK");
		$finish;
	end

endmodule
